// ----- rtl/core/price_time_order_matcher_assert.svh -----
// Assertion macros for the order matcher controller.
`ifndef PRICE_TIME_ORDER_MATCHER_ASSERT_SVH
`define PRICE_TIME_ORDER_MATCHER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PTOM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define PTOM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/ptom_pkg.sv -----
// Types, codes and defaults shared by the order matcher modules.
package ptom_pkg;

  localparam int BOOK_SLOTS_DEF = 16;

  // Request codes
  localparam logic REQ_SUBMIT = 1'b0;
  localparam logic REQ_CANCEL = 1'b1;

  // Event kinds
  localparam logic [1:0] EV_FILL   = 2'd0;
  localparam logic [1:0] EV_CANCEL = 2'd1;
  localparam logic [1:0] EV_ACK    = 2'd2;
  localparam logic [1:0] EV_REJECT = 2'd3;

  typedef struct packed {
    logic               req_type;
    logic [63:0]        order_id;
    logic               is_sell;
    logic signed [31:0] limit_price;
    logic [31:0]        quantity;
  } req_t;

  typedef struct packed {
    logic [1:0]         event_kind;
    logic [63:0]        event_order_id;
    logic [31:0]        fill_qty;
    logic signed [31:0] fill_price;
    logic               last_of_run;
  } evt_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EVAL,
    S_FILL_IN,
    S_FILL_REST
  } state_t;

  typedef enum logic [2:0] {
    EM_NONE,
    EM_FILL_IN,
    EM_FILL_REST,
    EM_CANCEL,
    EM_ACK,
    EM_REJECT
  } emit_t;

  // Controller to datapath
  typedef struct packed {
    logic  load;
    logic  clear;
    logic  step;
    logic  match;
    logic  place;
    logic  remove;
    emit_t emit;
    logic  last;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_skip;
    logic in_cancel;
    logic is_cancel;
    logic scan_last;
    logic best_valid;
    logic free_valid;
    logic fill_ends;
  } stat_t;

endpackage

// ----- rtl/core/price_time_order_matcher.sv -----
// Price-time priority limit order book, top level.
// A request is taken when start is high and busy is low. Each event leaves as
// one beat: result_valid is high for exactly one cycle and the receiver cannot
// stall it. A submit scans the book one slot per cycle and scans it again after
// each fill that does not use up the order; a cancel scans it once, and a
// zero-quantity submit neither scans nor gives an event. The event for the
// final beat of a request is on the result ports in the first cycle with busy
// low, so the next request may be taken at the edge that ends it.
module price_time_order_matcher
  import ptom_pkg::*;
#(
  parameter int BOOK_SLOTS = BOOK_SLOTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t request,
  output logic result_valid,
  output evt_t result
);

  cmd_t  cmd;
  stat_t stat;

  ptom_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  ptom_dp #(
    .BOOK_SLOTS (BOOK_SLOTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .request      (request),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

// ----- rtl/core/ptom_dp.sv -----
// Datapath: slot storage, one-slot-per-cycle best search, event register.
module ptom_dp
  import ptom_pkg::*;
#(
  parameter int BOOK_SLOTS = BOOK_SLOTS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  req_t  request,
  input  cmd_t  cmd,
  output stat_t stat,
  output logic  result_valid,
  output evt_t  result
);

  localparam int IW = (BOOK_SLOTS > 1) ? $clog2(BOOK_SLOTS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(BOOK_SLOTS - 1);

  // Slot storage
  logic               slot_valid     [BOOK_SLOTS];
  logic               slot_is_sell   [BOOK_SLOTS];
  logic signed [31:0] slot_price     [BOOK_SLOTS];
  logic [63:0]        slot_ident     [BOOK_SLOTS];
  logic [31:0]        slot_remaining [BOOK_SLOTS];
  logic [31:0]        slot_arrival   [BOOK_SLOTS];

  logic [31:0] arrival_counter;

  // Working registers for the current item
  req_t               req;
  logic [31:0]        stamp;
  logic [31:0]        rem;
  logic [IW-1:0]      idx;
  logic               best_valid;
  logic [IW-1:0]      best_idx;
  logic signed [31:0] best_price;
  logic [31:0]        best_age;
  logic [31:0]        best_rem;
  logic [63:0]        best_id;
  logic               free_valid;
  logic [IW-1:0]      free_idx;

  logic               cur_valid;
  logic signed [31:0] cur_price;
  logic [31:0]        cur_age;
  logic               cand;
  logic               take;
  logic               hit;
  logic [31:0]        fill_q;

  // Candidate test for the slot under the scan pointer
  always_comb begin
    cur_valid = slot_valid[idx];
    cur_price = slot_price[idx];
    cur_age   = stamp - slot_arrival[idx];
    cand = cur_valid && (slot_is_sell[idx] != req.is_sell) &&
           (req.is_sell ? (cur_price >= req.limit_price)
                        : (cur_price <= req.limit_price));
    if (!best_valid) begin
      take = 1'b1;
    end else if (cur_price != best_price) begin
      take = req.is_sell ? (cur_price > best_price) : (cur_price < best_price);
    end else begin
      take = cur_age > best_age;
    end
    hit    = cur_valid && (slot_ident[idx] == req.order_id);
    fill_q = (rem < best_rem) ? rem : best_rem;
  end

  // Status
  always_comb begin
    stat.in_skip    = (request.req_type == REQ_SUBMIT) && (request.quantity == 32'd0);
    stat.in_cancel  = (request.req_type == REQ_CANCEL);
    stat.is_cancel  = (req.req_type == REQ_CANCEL);
    stat.scan_last  = (idx == LAST_IDX);
    stat.best_valid = best_valid;
    stat.free_valid = free_valid;
    stat.fill_ends  = (rem <= best_rem);
  end

  // Item registers, scan state, counter
  always_ff @(posedge clk) begin
    if (rst) begin
      arrival_counter <= 32'd1;
      best_valid      <= 1'b0;
      free_valid      <= 1'b0;
      idx             <= '0;
    end else begin
      if (cmd.load) begin
        req <= request;
        rem <= request.quantity;
        if (request.req_type == REQ_SUBMIT) begin
          stamp           <= arrival_counter;
          arrival_counter <= arrival_counter + 32'd1;
        end
      end
      if (cmd.clear) begin
        best_valid <= 1'b0;
        free_valid <= 1'b0;
        idx        <= '0;
      end else if (cmd.step) begin
        if (req.req_type == REQ_CANCEL) begin
          if (hit && !best_valid) begin
            best_valid <= 1'b1;
            best_idx   <= idx;
          end
        end else if (cand && take) begin
          best_valid <= 1'b1;
          best_idx   <= idx;
          best_price <= cur_price;
          best_age   <= cur_age;
          best_rem   <= slot_remaining[idx];
          best_id    <= slot_ident[idx];
        end
        if (!cur_valid && !free_valid) begin
          free_valid <= 1'b1;
          free_idx   <= idx;
        end
        if (idx != LAST_IDX) begin
          idx <= idx + IW'(1);
        end
      end
      if (cmd.match) begin
        rem <= rem - fill_q;
      end
    end
  end

  // Slot writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BOOK_SLOTS; i++) begin
        slot_valid[i] <= 1'b0;
      end
    end else begin
      if (cmd.match) begin
        slot_remaining[best_idx] <= best_rem - fill_q;
        if (best_rem == fill_q) begin
          slot_valid[best_idx] <= 1'b0;
        end
      end
      if (cmd.remove) begin
        slot_valid[best_idx] <= 1'b0;
      end
      if (cmd.place) begin
        slot_valid[free_idx]     <= 1'b1;
        slot_is_sell[free_idx]   <= req.is_sell;
        slot_price[free_idx]     <= req.limit_price;
        slot_ident[free_idx]     <= req.order_id;
        slot_remaining[free_idx] <= rem;
        slot_arrival[free_idx]   <= stamp;
      end
    end
  end

  // Event beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (cmd.emit != EM_NONE);
    end
  end

  always_ff @(posedge clk) begin
    result.last_of_run    <= cmd.last;
    result.event_order_id <= req.order_id;
    result.fill_qty       <= 32'd0;
    result.fill_price     <= 32'sd0;
    unique case (cmd.emit)
      EM_FILL_IN: begin
        result.event_kind <= EV_FILL;
        result.fill_qty   <= fill_q;
        result.fill_price <= best_price;
      end
      EM_FILL_REST: begin
        result.event_kind     <= EV_FILL;
        result.event_order_id <= best_id;
        result.fill_qty       <= fill_q;
        result.fill_price     <= best_price;
      end
      EM_CANCEL: result.event_kind <= EV_CANCEL;
      EM_ACK:    result.event_kind <= EV_ACK;
      EM_REJECT: result.event_kind <= EV_REJECT;
      default:   result.event_kind <= EV_FILL;
    endcase
  end

endmodule

// ----- rtl/core/ptom_ctrl.sv -----
// Controller: sequences scans, fills, placement and cancels.
`include "price_time_order_matcher_assert.svh"
module ptom_ctrl
  import ptom_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output logic  busy,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.emit   = EM_NONE;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          cmd.clear = 1'b1;
          if (stat.in_cancel || !stat.in_skip) begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        if (stat.scan_last) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        state_next = S_IDLE;
        if (stat.is_cancel) begin
          if (stat.best_valid) begin
            cmd.remove = 1'b1;
            cmd.emit   = EM_CANCEL;
            cmd.last   = 1'b1;
          end
        end else if (stat.best_valid) begin
          state_next = S_FILL_IN;
        end else if (stat.free_valid) begin
          cmd.place = 1'b1;
          cmd.emit  = EM_ACK;
          cmd.last  = 1'b1;
        end else begin
          cmd.emit = EM_REJECT;
          cmd.last = 1'b1;
        end
      end
      S_FILL_IN: begin
        cmd.emit   = EM_FILL_IN;
        state_next = S_FILL_REST;
      end
      S_FILL_REST: begin
        cmd.emit  = EM_FILL_REST;
        cmd.match = 1'b1;
        cmd.last  = stat.fill_ends;
        if (stat.fill_ends) begin
          state_next = S_IDLE;
        end else begin
          cmd.clear  = 1'b1;
          state_next = S_SCAN;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  `PTOM_ASSERT_NEXT(a_accept_busy, start && !busy && !stat.in_skip, busy, "accepted item did not start work")
  `PTOM_ASSERT_NEXT(a_fill_pair, state == S_FILL_IN, state == S_FILL_REST, "incoming fill without resting fill")
  `PTOM_ASSERT_NOW(a_fill_has_best, state == S_FILL_IN || state == S_FILL_REST, stat.best_valid, "fill without a matched slot")

endmodule

// ----- bench/price_time_order_matcher_tb.sv -----
// Self-checking testbench for the price-time priority order matcher.
`timescale 1ns / 100ps

module price_time_order_matcher_tb;
  import ptom_pkg::*;

  localparam int SLOTS = BOOK_SLOTS_DEF;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  req_t request;
  logic result_valid;
  evt_t result;

  price_time_order_matcher #(.BOOK_SLOTS(SLOTS)) i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .result_valid (result_valid),
    .result       (result)
  );

  // Clock, 4 ns period
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Book mirror
  logic               book_live   [SLOTS];
  logic               book_sell   [SLOTS];
  logic signed [31:0] book_price  [SLOTS];
  logic [63:0]        book_id     [SLOTS];
  logic [31:0]        book_left   [SLOTS];
  logic [31:0]        book_stamp  [SLOTS];
  logic [31:0]        stamp_count;

  req_t   order_queue[$];
  evt_t   event_queue[$];
  logic [63:0] used_ids[$];
  int     n_taken;
  bit     failed = 1'b0;

  task automatic post_event(input logic [1:0] kind, input logic [63:0] id,
                            input logic [31:0] qty, input logic signed [31:0] px);
    evt_t e;
    e.event_kind     = kind;
    e.event_order_id = id;
    e.fill_qty       = qty;
    e.fill_price     = px;
    e.last_of_run    = 1'b0;
    event_queue = {event_queue, e};
  endtask

  // Work out the events that one request causes and update the mirror
  task automatic book_order(input req_t r);
    int n0;
    int best;
    int slot;
    logic signed [31:0] bp;
    logic [31:0] bage;
    logic [31:0] age;
    logic [31:0] rem;
    logic [31:0] m;
    logic [31:0] stamp;
    bit take;
    n0 = event_queue.size();
    if (r.req_type == REQ_CANCEL) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (book_live[i] && book_id[i] == r.order_id) begin
          book_live[i] = 1'b0;
          post_event(EV_CANCEL, r.order_id, '0, '0);
          break;
        end
      end
    end else begin
      stamp = stamp_count;
      stamp_count = stamp_count + 32'd1;
      rem = r.quantity;
      while (rem != 0) begin
        best = -1;
        bp = '0;
        bage = '0;
        for (int i = 0; i < SLOTS; i++) begin
          if (!book_live[i] || book_sell[i] == r.is_sell) continue;
          if (r.is_sell ? (book_price[i] < r.limit_price)
                        : (book_price[i] > r.limit_price)) continue;
          age = stamp - book_stamp[i];
          if (best < 0) take = 1'b1;
          else if (book_price[i] != bp)
            take = r.is_sell ? (book_price[i] > bp) : (book_price[i] < bp);
          else take = age > bage;
          if (take) begin
            best = i;
            bp = book_price[i];
            bage = age;
          end
        end
        if (best < 0) break;
        m = (rem < book_left[best]) ? rem : book_left[best];
        post_event(EV_FILL, r.order_id, m, bp);
        post_event(EV_FILL, book_id[best], m, bp);
        book_left[best] = book_left[best] - m;
        if (book_left[best] == 0) book_live[best] = 1'b0;
        rem = rem - m;
      end
      if (rem != 0) begin
        slot = -1;
        for (int i = 0; i < SLOTS; i++) begin
          if (!book_live[i]) begin
            slot = i;
            break;
          end
        end
        if (slot >= 0) begin
          book_live[slot]  = 1'b1;
          book_sell[slot]  = r.is_sell;
          book_price[slot] = r.limit_price;
          book_id[slot]    = r.order_id;
          book_left[slot]  = rem;
          book_stamp[slot] = stamp;
          post_event(EV_ACK, r.order_id, '0, '0);
        end else begin
          post_event(EV_REJECT, r.order_id, '0, '0);
        end
      end
    end
    if (event_queue.size() > n0)
      event_queue[event_queue.size() - 1].last_of_run = 1'b1;
  endtask

  // Sender gap odds by phase of the run
  function automatic int gap_pct(input int n);
    if (n < 40) return 17;
    if (n < 80) return 88;
    return 0;
  endfunction

  // Driver: one beat per accepted request
  always @(posedge clk) begin
    bit taken;
    bit raise;
    if (rst) begin
      start   <= 1'b0;
      request <= '0;
      for (int i = 0; i < SLOTS; i++) book_live[i] = 1'b0;
      stamp_count = 32'd1;
      n_taken = 0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        book_order(request);
        n_taken = n_taken + 1;
      end
      if (start && !taken) begin
        start <= 1'b1;
      end else begin
        raise = order_queue.size() != 0 && $urandom_range(99) >= gap_pct(n_taken);
        if (raise) begin
          request <= order_queue[0];
          order_queue.delete(0);
        end
        start <= raise;
      end
    end
  end

  // Monitor: compare each event beat with the oldest expectation
  always @(posedge clk) begin
    evt_t want;
    if (!rst && result_valid) begin
      if (event_queue.size() == 0) begin
        $error("unexpected event kind=%0d id=%h", result.event_kind,
               result.event_order_id);
        failed = 1'b1;
      end else begin
        want = event_queue[0];
        event_queue.delete(0);
        if (result.event_kind !== want.event_kind) begin
          $error("event_kind: expected %0d, got %0d", want.event_kind, result.event_kind);
          failed = 1'b1;
        end
        if (result.event_order_id !== want.event_order_id) begin
          $error("event_order_id: expected %h, got %h", want.event_order_id,
                 result.event_order_id);
          failed = 1'b1;
        end
        if (result.fill_qty !== want.fill_qty) begin
          $error("fill_qty: expected %0d, got %0d", want.fill_qty, result.fill_qty);
          failed = 1'b1;
        end
        if (result.fill_price !== want.fill_price) begin
          $error("fill_price: expected %0d, got %0d", want.fill_price, result.fill_price);
          failed = 1'b1;
        end
        if (result.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %0d, got %0d", want.last_of_run,
                 result.last_of_run);
          failed = 1'b1;
        end
      end
    end
  end

  task automatic add_order(input logic rt, input logic [63:0] id, input logic sell,
                           input logic signed [31:0] px, input logic [31:0] qty);
    req_t r;
    r.req_type    = rt;
    r.order_id    = id;
    r.is_sell     = sell;
    r.limit_price = px;
    r.quantity    = qty;
    order_queue = {order_queue, r};
    if (rt == REQ_SUBMIT) used_ids = {used_ids, id};
  endtask

  // Stimulus and end of run
  initial begin
    logic [63:0] id;
    logic signed [31:0] px;
    logic [31:0] qty;
    int pick;
    rst = 1'b1;

    // Directed: extremes, zero quantity, unknown cancel, full book, full sweep
    add_order(REQ_SUBMIT, 64'h0, 1'b0, 32'sh7FFFFFFF, 32'hFFFFFFFF);
    add_order(REQ_SUBMIT, 64'hFFFFFFFFFFFFFFFF, 1'b0, 32'sh80000000, 32'd1);
    add_order(REQ_SUBMIT, 64'h55, 1'b1, 32'sd10, 32'd0);
    add_order(REQ_CANCEL, 64'hDEAD, 1'b0, '0, '0);
    for (int i = 0; i < SLOTS - 2; i++)
      add_order(REQ_SUBMIT, 64'h100 + i, 1'b0, 32'sd100 + (i % 4), 32'd3 + i);
    add_order(REQ_SUBMIT, 64'h200, 1'b0, 32'sd50, 32'd9);
    add_order(REQ_CANCEL, 64'h105, 1'b1, 32'sd7, 32'd7);
    add_order(REQ_SUBMIT, 64'h300, 1'b1, 32'sh80000000, 32'hFFFFFFFF);
    add_order(REQ_CANCEL, 64'h300, 1'b0, '0, '0);

    // Random: mostly a tight price band so orders cross, some wide values
    for (int k = 0; k < 98; k++) begin
      if ($urandom_range(99) < 22) begin
        pick = $urandom_range(used_ids.size() - 1);
        id = ($urandom_range(99) < 80) ? used_ids[pick] : {$urandom, $urandom};
        add_order(REQ_CANCEL, id, $urandom_range(1), $urandom, $urandom);
      end else begin
        id = {$urandom, $urandom};
        px = ($urandom_range(99) < 90) ? 32'sd1000 + $urandom_range(15) : $urandom;
        pick = $urandom_range(99);
        qty = (pick < 5) ? 32'd0 : (pick < 12) ? $urandom : $urandom_range(1, 40);
        add_order(REQ_SUBMIT, id, $urandom_range(1), px, qty);
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    wait (order_queue.size() == 0 && start == 1'b0 && event_queue.size() == 0);
    repeat (4 * (SLOTS + 3)) @(posedge clk);
    if (failed || event_queue.size() != 0) begin
      $display("Simulation FAILED");
    end else begin
      $display("Simulation PASSED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
